@@ design/assert_macros.svh @@
// assertion macros shared by the tessellator rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clock edge outside reset
`define QBT_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("qbt assertion failed");

// condition must never be true outside reset
`define QBT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("qbt forbidden condition seen");

`endif

@@ design/qbt_pkg.sv @@
// shared types and constants of the quadratic bezier tessellator
`default_nettype none

package qbt_pkg;

    // field widths
    localparam int COORD_W   = 16;
    localparam int IDX_W     = 6;
    localparam int INC_W     = 17;
    localparam int T_W       = 23;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 17;

    // number of register stages from issue to output word
    localparam int PIPE_DEPTH = 5;

    // strip length limit and t = 1.0 in q7.16
    localparam logic [IDX_W-1:0] MAX_STEPS = 6'd63;
    localparam logic [T_W-1:0]   T_ONE     = 23'h010000;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_INC   = 2'd1;

    // configuration reset values
    localparam logic [IDX_W-1:0] STEP_COUNT_RST = 6'd16;
    localparam logic [INC_W-1:0] STEP_INC_RST   = 17'd4096;

    // one axis of a curve with its precomputed differences
    typedef struct packed {
        logic signed [COORD_W-1:0] a;
        logic signed [COORD_W-1:0] b;
        logic signed [COORD_W:0]   dab;
        logic signed [COORD_W:0]   dbc;
    } qbt_axis_t;

    // one point issued by the sequencer
    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] idx;
        logic             last;
        logic [T_W-1:0]   t;
    } qbt_issue_t;

endpackage

`default_nettype wire

@@ design/quadratic_bezier_tessellator_unit.sv @@
// top level of the quadratic bezier tessellator
//
// Input channel (s_*): one word is one quadratic curve, three control points
// in signed q12.4. Output channel (m_*): one word is one strip point with its
// index and a last flag; a curve gives step_count+1 points (step_count zero
// counts as one), the first the start point, the last the end point, exact.
// Configuration: cfg_wr_en/cfg_index/cfg_data write step_count (index 0) and
// step_increment (index 1, q1.16); other indexes are ignored. Write only
// while the block is idle.
// The sequencer registers an accepted curve and then issues its first point
// into a five-stage datapath of two multiply levels.
// Throughput: one point per cycle unless m_ready stalls; the sequencer, the
// bound, holds a curve of n segments until its n+1 points are issued and takes
// a new one only then: s_ready is high whenever it holds no curve.
// Reset (aresetn low, synchronous) empties the pipeline, drops any curve in
// progress and restores step_count 16, step_increment 4096.
// When m_valid is high and m_ready low the whole pipeline holds; no point is
// lost or repeated.
`default_nettype none

`include "assert_macros.svh"

module quadratic_bezier_tessellator_unit (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    // configuration
    input  wire logic                                cfg_wr_en,
    input  wire logic [qbt_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [qbt_pkg::CFG_W-1:0]           cfg_data,
    // curve input
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic signed [qbt_pkg::COORD_W-1:0]  s_start_x,
    input  wire logic signed [qbt_pkg::COORD_W-1:0]  s_start_y,
    input  wire logic signed [qbt_pkg::COORD_W-1:0]  s_ctrl_x,
    input  wire logic signed [qbt_pkg::COORD_W-1:0]  s_ctrl_y,
    input  wire logic signed [qbt_pkg::COORD_W-1:0]  s_end_x,
    input  wire logic signed [qbt_pkg::COORD_W-1:0]  s_end_y,
    // point output
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic signed [qbt_pkg::COORD_W-1:0]       m_point_x,
    output logic signed [qbt_pkg::COORD_W-1:0]       m_point_y,
    output logic [qbt_pkg::IDX_W-1:0]                m_point_index,
    output logic                                     m_last_point
);

    localparam int LAST = qbt_pkg::PIPE_DEPTH - 1;

    logic [qbt_pkg::IDX_W-1:0]  step_count_reg;
    logic [qbt_pkg::INC_W-1:0]  step_inc_reg;

    qbt_pkg::qbt_issue_t        issue;
    qbt_pkg::qbt_axis_t         curve_x, curve_y;
    logic                       adv;

    logic [qbt_pkg::PIPE_DEPTH-1:0] vld_reg;
    logic [qbt_pkg::IDX_W-1:0]      idx_reg  [qbt_pkg::PIPE_DEPTH];
    logic [qbt_pkg::PIPE_DEPTH-1:0] last_reg;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_count_reg <= qbt_pkg::STEP_COUNT_RST;
            step_inc_reg   <= qbt_pkg::STEP_INC_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                qbt_pkg::CFG_STEP_COUNT: step_count_reg <= cfg_data[qbt_pkg::IDX_W-1:0];
                qbt_pkg::CFG_STEP_INC:   step_inc_reg   <= cfg_data[qbt_pkg::INC_W-1:0];
                default: ;
            endcase
        end
    end

    // the pipeline moves as a whole unless the output word is stalled
    assign adv = !vld_reg[LAST] || m_ready;

    qbt_seq u_seq (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .start_x        (s_start_x),
        .start_y        (s_start_y),
        .ctrl_x         (s_ctrl_x),
        .ctrl_y         (s_ctrl_y),
        .end_x          (s_end_x),
        .end_y          (s_end_y),
        .step_count     (step_count_reg),
        .step_increment (step_inc_reg),
        .adv            (adv),
        .issue_o        (issue),
        .curve_x_o      (curve_x),
        .curve_y_o      (curve_y)
    );

    qbt_axis u_axis_x (
        .aclk    (aclk),
        .adv     (adv),
        .t_in    (issue.t),
        .curve_i (curve_x),
        .point_o (m_point_x)
    );

    qbt_axis u_axis_y (
        .aclk    (aclk),
        .adv     (adv),
        .t_in    (issue.t),
        .curve_i (curve_y),
        .point_o (m_point_y)
    );

    // valid bits alongside the datapath stages
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[LAST-1:0], issue.valid};
        end
    end

    // point index and last flag alongside the datapath stages
    always_ff @(posedge aclk) begin
        if (adv) begin
            idx_reg[0]  <= issue.idx;
            last_reg[0] <= issue.last;
            for (int k = 1; k < qbt_pkg::PIPE_DEPTH; k++) begin
                idx_reg[k]  <= idx_reg[k-1];
                last_reg[k] <= last_reg[k-1];
            end
        end
    end

    assign m_valid       = vld_reg[LAST];
    assign m_point_index = idx_reg[LAST];
    assign m_last_point  = last_reg[LAST];

    `QBT_ASSERT(a_last_not_first, aclk, aresetn, (m_valid && m_last_point) |-> (m_point_index != '0))
    `QBT_ASSERT(a_stall_holds_index, aclk, aresetn, (m_valid && !m_ready) |=> $stable(m_point_index))
    `QBT_ASSERT(a_stall_holds_x, aclk, aresetn, (m_valid && !m_ready) |=> $stable(m_point_x))

endmodule

`default_nettype wire

@@ design/qbt_seq.sv @@
// point sequencer: holds one curve and issues one t value per cycle while adv is high
`default_nettype none

`include "assert_macros.svh"

module qbt_seq (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic signed [qbt_pkg::COORD_W-1:0] start_x,
    input  wire logic signed [qbt_pkg::COORD_W-1:0] start_y,
    input  wire logic signed [qbt_pkg::COORD_W-1:0] ctrl_x,
    input  wire logic signed [qbt_pkg::COORD_W-1:0] ctrl_y,
    input  wire logic signed [qbt_pkg::COORD_W-1:0] end_x,
    input  wire logic signed [qbt_pkg::COORD_W-1:0] end_y,
    input  wire logic [qbt_pkg::IDX_W-1:0]      step_count,
    input  wire logic [qbt_pkg::INC_W-1:0]      step_increment,
    input  wire logic                           adv,
    output qbt_pkg::qbt_issue_t                 issue_o,
    output qbt_pkg::qbt_axis_t                  curve_x_o,
    output qbt_pkg::qbt_axis_t                  curve_y_o
);

    logic                          busy_reg, busy_next;
    logic [qbt_pkg::IDX_W-1:0]     idx_reg, idx_next;
    logic [qbt_pkg::IDX_W-1:0]     n_reg, n_next;
    logic [qbt_pkg::T_W-1:0]       tacc_reg, tacc_next;
    qbt_pkg::qbt_axis_t            cx_reg, cy_reg;
    logic [qbt_pkg::IDX_W-1:0]     n_eff;
    logic                          accept;
    logic                          issue_last;
    logic                          issue_fire;

    // effective segment count, zero counts as one and counts above MAX_STEPS are capped
    always_comb begin
        if (step_count == '0) begin
            n_eff = qbt_pkg::IDX_W'(1);
        end else if (step_count > qbt_pkg::MAX_STEPS) begin
            n_eff = qbt_pkg::MAX_STEPS;
        end else begin
            n_eff = step_count;
        end
    end

    assign accept     = s_valid && !busy_reg;
    assign issue_last = (idx_reg == n_reg);
    assign issue_fire = busy_reg && adv;
    assign s_ready    = !busy_reg;

    // sequencer next state
    always_comb begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        n_next    = n_reg;
        tacc_next = tacc_reg;
        if (accept) begin
            busy_next = 1'b1;
            idx_next  = '0;
            n_next    = n_eff;
            tacc_next = '0;
        end else if (issue_fire) begin
            busy_next = !issue_last;
            idx_next  = idx_reg + qbt_pkg::IDX_W'(1);
            tacc_next = tacc_reg + qbt_pkg::T_W'(step_increment);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
            n_reg    <= qbt_pkg::IDX_W'(1);
            tacc_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
            n_reg    <= n_next;
            tacc_reg <= tacc_next;
        end
    end

    // curve capture with the two differences per axis
    always_ff @(posedge aclk) begin
        if (accept) begin
            cx_reg.a   <= start_x;
            cx_reg.b   <= ctrl_x;
            cx_reg.dab <= 17'(ctrl_x) - 17'(start_x);
            cx_reg.dbc <= 17'(end_x) - 17'(ctrl_x);
            cy_reg.a   <= start_y;
            cy_reg.b   <= ctrl_y;
            cy_reg.dab <= 17'(ctrl_y) - 17'(start_y);
            cy_reg.dbc <= 17'(end_y) - 17'(ctrl_y);
        end
    end

    // issue word: t runs 0, inc, 2*inc, ... and is exactly 1.0 on the end point
    always_comb begin
        issue_o.valid = busy_reg;
        issue_o.idx   = idx_reg;
        issue_o.last  = issue_last;
        issue_o.t     = issue_last ? qbt_pkg::T_ONE : tacc_reg;
    end

    assign curve_x_o = cx_reg;
    assign curve_y_o = cy_reg;

    `QBT_ASSERT(a_accept_starts, aclk, aresetn, accept |=> (busy_reg && idx_reg == '0))
    `QBT_NEVER(a_idx_in_range, aclk, aresetn, busy_reg && (idx_reg > n_reg))
    `QBT_ASSERT(a_last_ends, aclk, aresetn, (issue_fire && issue_last) |=> !busy_reg)

endmodule

`default_nettype wire

@@ design/qbt_axis.sv @@
// five-stage de casteljau datapath for one coordinate axis
`default_nettype none

module qbt_axis (
    input  wire logic                            aclk,
    input  wire logic                            adv,
    input  wire logic [qbt_pkg::T_W-1:0]         t_in,
    input  wire qbt_pkg::qbt_axis_t              curve_i,
    output logic signed [qbt_pkg::COORD_W-1:0]   point_o
);

    localparam int TS_W = qbt_pkg::T_W + 1;
    localparam int D1_W = qbt_pkg::COORD_W + 1;
    localparam int M1_W = TS_W + D1_W;
    localparam int P_W  = M1_W - 16 + 1;
    localparam int D2_W = P_W + 1;
    localparam int M2_W = TS_W + D2_W;
    localparam int R_W  = M2_W - 16 + 1;

    localparam logic signed [R_W-1:0] SAT_HI = R_W'(32767);
    localparam logic signed [R_W-1:0] SAT_LO = -R_W'(32768);

    // stage 1: first-level products
    logic [qbt_pkg::T_W-1:0]             t1_reg;
    logic signed [qbt_pkg::COORD_W-1:0]  a1_reg, b1_reg;
    logic signed [M1_W-1:0]              mab1_reg, mbc1_reg;
    logic signed [M1_W-1:0]              mab1_next, mbc1_next;
    // stage 2: first-level lerps
    logic [qbt_pkg::T_W-1:0]             t2_reg;
    logic signed [P_W-1:0]               p2_reg, q2_reg, p2_next, q2_next;
    // stage 3: difference of the two lerps
    logic [qbt_pkg::T_W-1:0]             t3_reg;
    logic signed [P_W-1:0]               p3_reg;
    logic signed [D2_W-1:0]              d3_reg, d3_next;
    // stage 4: second-level product
    logic signed [P_W-1:0]               p4_reg;
    logic signed [M2_W-1:0]              m4_reg, m4_next;
    // stage 5: final lerp with saturation
    logic signed [R_W-1:0]               r5;
    logic signed [qbt_pkg::COORD_W-1:0]  pt_reg, pt_next;

    logic signed [TS_W-1:0] t0_s, t3_s;

    assign t0_s = $signed({1'b0, t_in});
    assign t3_s = $signed({1'b0, t3_reg});

    // first-level products t*(b-a) and t*(c-b)
    assign mab1_next = M1_W'(t0_s) * M1_W'(curve_i.dab);
    assign mbc1_next = M1_W'(t0_s) * M1_W'(curve_i.dbc);

    // floor shift by 16 and add the base points
    assign p2_next = P_W'(a1_reg) + P_W'($signed(mab1_reg[M1_W-1:16]));
    assign q2_next = P_W'(b1_reg) + P_W'($signed(mbc1_reg[M1_W-1:16]));

    assign d3_next = D2_W'(q2_reg) - D2_W'(p2_reg);

    assign m4_next = M2_W'(t3_s) * M2_W'(d3_reg);

    // final lerp and clamp to the coordinate range
    always_comb begin
        r5 = R_W'(p4_reg) + R_W'($signed(m4_reg[M2_W-1:16]));
        if (r5 > SAT_HI) begin
            pt_next = 16'sh7FFF;
        end else if (r5 < SAT_LO) begin
            pt_next = -16'sh8000;
        end else begin
            pt_next = r5[qbt_pkg::COORD_W-1:0];
        end
    end

    // pipeline registers, all held on a stall
    always_ff @(posedge aclk) begin
        if (adv) begin
            t1_reg   <= t_in;
            a1_reg   <= curve_i.a;
            b1_reg   <= curve_i.b;
            mab1_reg <= mab1_next;
            mbc1_reg <= mbc1_next;
            t2_reg   <= t1_reg;
            p2_reg   <= p2_next;
            q2_reg   <= q2_next;
            t3_reg   <= t2_reg;
            p3_reg   <= p2_reg;
            d3_reg   <= d3_next;
            p4_reg   <= p3_reg;
            m4_reg   <= m4_next;
            pt_reg   <= pt_next;
        end
    end

    assign point_o = pt_reg;

endmodule

`default_nettype wire

@@ dv/tb_top.sv @@
// self-checking testbench for the quadratic bezier tessellator unit
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    // register indexes that the block has no register behind
    localparam logic [qbt_pkg::CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [qbt_pkg::CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

    localparam int CURVE_TARGET = 480;
    localparam int DRAIN_LIMIT  = 200000;

    typedef logic signed [qbt_pkg::COORD_W-1:0] coord_t;

    typedef struct packed {
        coord_t start_x;
        coord_t start_y;
        coord_t ctrl_x;
        coord_t ctrl_y;
        coord_t end_x;
        coord_t end_y;
    } curve_t;

    typedef struct packed {
        coord_t                    x;
        coord_t                    y;
        logic [qbt_pkg::IDX_W-1:0] idx;
        logic                      last;
    } point_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;

    logic                          cfg_wr_en = 1'b0;
    logic [qbt_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [qbt_pkg::CFG_W-1:0]     cfg_data = '0;

    logic   s_valid = 1'b0;
    logic   s_ready;
    coord_t s_start_x = '0;
    coord_t s_start_y = '0;
    coord_t s_ctrl_x = '0;
    coord_t s_ctrl_y = '0;
    coord_t s_end_x = '0;
    coord_t s_end_y = '0;

    logic                      m_valid;
    logic                      m_ready = 1'b0;
    coord_t                    m_point_x;
    coord_t                    m_point_y;
    logic [qbt_pkg::IDX_W-1:0] m_point_index;
    logic                      m_last_point;

    // local copy of the configuration registers
    logic [qbt_pkg::IDX_W-1:0] seg_count_reg = qbt_pkg::STEP_COUNT_RST;
    logic [qbt_pkg::INC_W-1:0] t_step_reg = qbt_pkg::STEP_INC_RST;

    curve_t pending_curves[$];
    point_t expected_points[$];
    int     mismatches = 0;
    int     curves_queued = 0;

    quadratic_bezier_tessellator_unit u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_start_x     (s_start_x),
        .s_start_y     (s_start_y),
        .s_ctrl_x      (s_ctrl_x),
        .s_ctrl_y      (s_ctrl_y),
        .s_end_x       (s_end_x),
        .s_end_y       (s_end_y),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_point_x     (m_point_x),
        .m_point_y     (m_point_y),
        .m_point_index (m_point_index),
        .m_last_point  (m_last_point)
    );

    always #5 aclk = ~aclk;

    // q1.16 lerp, floor on the shift, full width
    function automatic longint lerp_q16(longint a, longint b, longint t);
        return a + ((t * (b - a)) >>> 16);
    endfunction

    function automatic coord_t clamp_coord(longint v);
        if (v > 32767) begin
            return 16'sd32767;
        end
        if (v < -32768) begin
            return -16'sd32768;
        end
        return coord_t'(v);
    endfunction

    function automatic point_t make_point(longint x, longint y, longint idx, logic last);
        point_t p;
        p.x = clamp_coord(x);
        p.y = clamp_coord(y);
        p.idx = idx[qbt_pkg::IDX_W-1:0];
        p.last = last;
        return p;
    endfunction

    function automatic void expect_point(point_t p);
        expected_points = {expected_points, p};
    endfunction

    // de casteljau strip for one curve under the current registers
    function automatic void predict_strip(curve_t c);
        longint n;
        longint t;
        longint px, py, qx, qy;
        n = seg_count_reg;
        if (n == 0) begin
            n = 1;
        end
        if (n > qbt_pkg::MAX_STEPS) begin
            n = qbt_pkg::MAX_STEPS;
        end
        expect_point(make_point(c.start_x, c.start_y, 0, 1'b0));
        for (longint i = 1; i < n; i++) begin
            t = i * longint'(t_step_reg);
            px = lerp_q16(c.start_x, c.ctrl_x, t);
            py = lerp_q16(c.start_y, c.ctrl_y, t);
            qx = lerp_q16(c.ctrl_x, c.end_x, t);
            qy = lerp_q16(c.ctrl_y, c.end_y, t);
            expect_point(make_point(lerp_q16(px, qx, t), lerp_q16(py, qy, t), i, 1'b0));
        end
        expect_point(make_point(c.end_x, c.end_y, n, 1'b1));
    endfunction

    function automatic curve_t make_curve(longint sx, longint sy, longint cx, longint cy,
                                          longint ex, longint ey);
        curve_t c;
        c.start_x = coord_t'(sx);
        c.start_y = coord_t'(sy);
        c.ctrl_x = coord_t'(cx);
        c.ctrl_y = coord_t'(cy);
        c.end_x = coord_t'(ex);
        c.end_y = coord_t'(ey);
        return c;
    endfunction

    function automatic coord_t pick_extreme();
        case ($urandom_range(0, 3))
            0: return -16'sd32768;
            1: return 16'sd32767;
            2: return 16'sd0;
            default: return -16'sd1;
        endcase
    endfunction

    // mostly full-range curves, some local shapes, extremes and collapsed ones
    function automatic curve_t random_curve();
        curve_t c;
        int     mode;
        int     cx, cy, span;
        mode = $urandom_range(0, 9);
        if (mode <= 5) begin
            c = curve_t'({$urandom(), $urandom(), $urandom()});
        end else if (mode <= 7) begin
            cx = $signed($urandom_range(0, 65535)) - 32768;
            cy = $signed($urandom_range(0, 65535)) - 32768;
            span = $urandom_range(1, 4096);
            c = make_curve(cx + $urandom_range(0, 2 * span) - span,
                           cy + $urandom_range(0, 2 * span) - span,
                           cx + $urandom_range(0, 2 * span) - span,
                           cy + $urandom_range(0, 2 * span) - span,
                           cx + $urandom_range(0, 2 * span) - span,
                           cy + $urandom_range(0, 2 * span) - span);
        end else if (mode == 8) begin
            c = make_curve(pick_extreme(), pick_extreme(), pick_extreme(),
                           pick_extreme(), pick_extreme(), pick_extreme());
        end else begin
            cx = $signed($urandom_range(0, 65535)) - 32768;
            cy = $signed($urandom_range(0, 65535)) - 32768;
            c = make_curve(cx, cy, cx, cy, cx, cy);
        end
        return c;
    endfunction

    task automatic queue_curve(curve_t c);
        pending_curves = {pending_curves, c};
        curves_queued++;
    endtask

    task automatic write_reg(logic [qbt_pkg::CFG_IDX_W-1:0] idx,
                             logic [qbt_pkg::CFG_W-1:0] data);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == qbt_pkg::CFG_STEP_COUNT) begin
            seg_count_reg = data[qbt_pkg::IDX_W-1:0];
        end else if (idx == qbt_pkg::CFG_STEP_INC) begin
            t_step_reg = data[qbt_pkg::INC_W-1:0];
        end
    endtask

    // block idle: nothing queued, nothing offered, nothing outstanding
    task automatic wait_idle();
        do begin
            @(negedge aclk);
        end while (pending_curves.size() != 0 || s_valid || expected_points.size() != 0);
        repeat (qbt_pkg::PIPE_DEPTH + 6) @(posedge aclk);
    endtask

    task automatic set_strip(logic [qbt_pkg::CFG_W-1:0] count_data,
                             logic [qbt_pkg::CFG_W-1:0] inc_data);
        wait_idle();
        write_reg(qbt_pkg::CFG_STEP_COUNT, count_data);
        write_reg(qbt_pkg::CFG_STEP_INC, inc_data);
    endtask

    // curve driver: bursts of words with random gaps
    int burst_left = 1;
    int gap_left = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                predict_strip({s_start_x, s_start_y, s_ctrl_x, s_ctrl_y, s_end_x, s_end_y});
            end
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    s_valid <= 1'b0;
                end else if (pending_curves.size() != 0) begin
                    curve_t c;
                    c = pending_curves.pop_front();
                    s_start_x <= c.start_x;
                    s_start_y <= c.start_y;
                    s_ctrl_x <= c.ctrl_x;
                    s_ctrl_y <= c.ctrl_y;
                    s_end_x <= c.end_x;
                    s_end_y <= c.end_y;
                    s_valid <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 8);
                        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // point receiver: stall mode changes when its random timer runs out
    int stall_mode = 0;
    int stall_timer = 0;
    int rx_cycle = 0;

    always @(posedge aclk) begin
        rx_cycle <= rx_cycle + 1;
        if (stall_timer == 0) begin
            stall_mode <= $urandom_range(0, 3);
            stall_timer <= $urandom_range(50, 300);
        end else begin
            stall_timer <= stall_timer - 1;
        end
        case (stall_mode)
            0: m_ready <= 1'b1;
            1: m_ready <= 1'($urandom_range(0, 1));
            2: m_ready <= ($urandom_range(0, 3) == 0);
            default: m_ready <= (rx_cycle % 7) < 4;
        endcase
    end

    task automatic compare_field(string name, longint want, longint got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    // point monitor
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_points.size() == 0) begin
                $display("%0t: unexpected point, expected none, actual x=%0d y=%0d idx=%0d",
                         $time, m_point_x, m_point_y, m_point_index);
                mismatches++;
            end else begin
                point_t p;
                p = expected_points.pop_front();
                compare_field("point_x", p.x, m_point_x);
                compare_field("point_y", p.y, m_point_y);
                compare_field("point_index", p.idx, m_point_index);
                compare_field("last_point", p.last, m_last_point);
            end
        end
    end

    // stimulus
    initial begin
        int phase_len;
        int n_eff;
        int drain;
        logic [qbt_pkg::CFG_W-1:0] inc_pick;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // reset registers: field extremes and strong bends
        queue_curve(make_curve(0, 0, 0, 0, 0, 0));
        queue_curve(make_curve(32767, 32767, 32767, 32767, 32767, 32767));
        queue_curve(make_curve(-32768, -32768, -32768, -32768, -32768, -32768));
        queue_curve(make_curve(-32768, -32768, 32767, 32767, -32768, -32768));
        queue_curve(make_curve(32767, -32768, -32768, 32767, 32767, -32768));
        queue_curve(make_curve(-1000, 500, 0, 0, 1000, -500));

        // zero step count acts as one; upper data bits are dropped
        set_strip(17'h1FFC0, 17'd65536);
        queue_curve(make_curve(-32768, 32767, 0, 0, 32767, -32768));
        queue_curve(random_curve());

        // longest strip with maximum increment, extrapolation saturates
        set_strip(17'd63, 17'h1FFFF);
        queue_curve(make_curve(-32768, -32768, 32767, 32767, -32768, -32768));
        queue_curve(make_curve(32767, -32768, -32768, 32767, 32767, -32768));
        queue_curve(random_curve());

        // zero increment, spare register indexes ignored
        set_strip(17'd2, 17'd0);
        write_reg(CFG_SPARE_2, 17'h1FFFF);
        write_reg(CFG_SPARE_3, 17'd5);
        queue_curve(make_curve(100, -200, 3000, 4000, -5000, 6000));
        queue_curve(random_curve());

        // longest strip with matching increment
        set_strip(17'd63, 17'd1040);
        queue_curve(make_curve(-32768, 32767, 32767, -32768, -32768, 32767));
        queue_curve(random_curve());

        // increment that does not match the count, end still exact
        set_strip(17'd5, 17'd65535);
        queue_curve(make_curve(-32768, -32768, 32767, -32768, 32767, 32767));
        queue_curve(random_curve());

        // random phases
        while (curves_queued < CURVE_TARGET) begin
            case ($urandom_range(0, 9))
                0: n_eff = 0;
                1: n_eff = 63;
                2: n_eff = 1;
                3, 4: n_eff = $urandom_range(1, 63);
                default: n_eff = $urandom_range(2, 20);
            endcase
            case ($urandom_range(0, 9))
                0: inc_pick = 17'd0;
                1: inc_pick = 17'h1FFFF;
                2: inc_pick = 17'd65536;
                3, 4: inc_pick = qbt_pkg::CFG_W'($urandom_range(0, 17'h1FFFF));
                default: inc_pick = qbt_pkg::CFG_W'(65536 / ((n_eff == 0) ? 1 : n_eff));
            endcase
            set_strip(qbt_pkg::CFG_W'(n_eff | ($urandom_range(0, 2047) << qbt_pkg::IDX_W)),
                      inc_pick);
            if ($urandom_range(0, 3) == 0) begin
                write_reg($urandom_range(0, 1) ? CFG_SPARE_2 : CFG_SPARE_3,
                          qbt_pkg::CFG_W'($urandom()));
            end
            phase_len = (n_eff > 30) ? $urandom_range(5, 15) : $urandom_range(20, 50);
            repeat (phase_len) queue_curve(random_curve());
        end

        // drain
        do begin
            @(negedge aclk);
        end while (pending_curves.size() != 0 || s_valid);
        drain = 0;
        while (expected_points.size() != 0 && drain < DRAIN_LIMIT) begin
            @(negedge aclk);
            drain++;
        end
        repeat (qbt_pkg::PIPE_DEPTH + 20) @(posedge aclk);
        @(negedge aclk);
        if (expected_points.size() != 0) begin
            $display("%0t: missing points, expected %0d more, actual 0",
                     $time, expected_points.size());
            mismatches++;
        end
        if (mismatches == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

    // watchdog
    initial begin
        #20ms;
        $display("tb_top: errors");
        $finish;
    end

endmodule

`default_nettype wire
